### rtl/core/asmon_pkg.sv
`timescale 1ns / 1ps
// asmon_pkg: shared types and constants of the ADC sample statistics monitor.
// No dependencies.
package asmon_pkg;

   // sample and raw word layout
   localparam int RAW_W     = 16;
   localparam int SAMPLE_W  = 12;
   localparam int UPPER_W   = RAW_W - SAMPLE_W;
   localparam int SUM_W     = 44;
   localparam int SQUARE_W  = 56;
   localparam int OUT_CNT_W = 32;
   localparam int OUT_IDX_W = 3;
   localparam int RSP_DATA_W = 288;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

   // parameter defaults
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int BIN_COUNT_DEF   = 8;

   // band ratio for the pass check: band > floor(count * 99 / 100)
   localparam int PASS_NUM = 99;
   localparam int PASS_DEN = 100;

   // register reset values
   localparam logic [SAMPLE_W-1:0] BAND_LOW_RST  = 12'd1948;
   localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST = 12'd2148;
   localparam logic [SAMPLE_W-1:0] MEAN_LOW_RST  = 12'd1900;
   localparam logic [SAMPLE_W-1:0] MEAN_HIGH_RST = 12'd2200;

   localparam int CSR_ADDR_W = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BAND_LOW  = 2'd0,
      CSR_BAND_HIGH = 2'd1,
      CSR_MEAN_LOW  = 2'd2,
      CSR_MEAN_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_SETTLE,
      ST_EVAL,
      ST_LOAD,
      ST_HOLD
   } state_type;

   // control from the sequencer to the histogram store
   typedef struct packed {
      logic upd;    // count one sample into upd_bin
      logic rd;     // report read of rd_bin
      logic clear;  // drop all bins
   } bins_ctrl_type;

endpackage

### rtl/core/adc_sample_statistics_monitor_core.sv
`timescale 1ns / 1ps
// adc_sample_statistics_monitor_core: top level of the ADC run statistics monitor.
// Depends on asmon_pkg, asmon_stats, asmon_bins (asmon_ram).
//
// Channel  Dir  Handshake              Content
// req_     in   req_tvalid/req_tready  raw ADC word, tlast closes the run
// rsp_     out  rsp_tvalid/rsp_tready  one report per bin, tlast on the final bin
// csr_     in   csr_wen                band and mean limits, write only
//
// During a run one word is taken every cycle; the bin count goes through a
// read-modify-write of the bin RAM with a one-deep forward for repeated bins.
// After the tlast word the sequencer passes SETTLE and EVAL while the last bin write
// lands and the pass flag settles, then LOAD and HOLD per bin, HOLD waiting out any
// rsp stall. The first result is valid in the first HOLD; req_tready stays low from
// the tlast transfer until the final report is taken.
// Reset is synchronous; the bin RAM is not swept, per-bin valid flops mark
// it empty, so the block takes words the cycle after reset is released.
module adc_sample_statistics_monitor_core #(
   parameter int COUNT_WIDTH = asmon_pkg::COUNT_WIDTH_DEF,
   parameter int BIN_COUNT   = asmon_pkg::BIN_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [15:0] raw_word
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [asmon_pkg::RAW_W-1:0]          req_tdata,
   input  logic                                 req_tlast,
   // rsp_tdata: [2:0] bin_index, [34:3] bin_count, [66:35] sample_count,
   //   [78:67] min_value, [90:79] max_value, [134:91] value_sum,
   //   [190:135] square_sum, [222:191] zero_count, [254:223] upper_set_count,
   //   [286:255] band_count, [287] pass_flag
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [asmon_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_wen,
   input  logic [asmon_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [asmon_pkg::SAMPLE_W-1:0]       csr_wdata
);

   localparam int SW    = asmon_pkg::SAMPLE_W;
   localparam int BIN_W = $clog2(BIN_COUNT);
   localparam int BPW   = SW + BIN_W;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

   // configuration
   logic [SW-1:0] band_low_ff, band_high_ff, mean_low_ff, mean_high_ff;

   // sequencer
   asmon_pkg::state_type     state_ff, state_in;
   logic [BIN_W-1:0]         bin_ff, bin_in;
   asmon_pkg::bins_ctrl_type bins_ctrl;
   logic [BIN_W-1:0]         rd_bin;
   logic                     rsp_load;
   logic                     rsp_take;
   logic                     stats_clear;
   logic                     accept;
   logic                     take;

   // sample to bin: (s * BIN_COUNT) >> 12
   logic [BPW-1:0]           bin_prod;
   logic [BIN_W-1:0]         upd_bin;

   // statistics
   logic                              full;
   logic [COUNT_WIDTH-1:0]            count;
   logic [SW-1:0]                     min_value, max_value;
   logic [asmon_pkg::SUM_W-1:0]       value_sum;
   logic [asmon_pkg::SQUARE_W-1:0]    square_sum;
   logic [COUNT_WIDTH-1:0]            zero_count, upper_count, band_count;
   logic                              pass;
   logic [COUNT_WIDTH-1:0]            rd_count;

   // result register
   logic                              rsp_tvalid_ff;
   logic [asmon_pkg::RSP_DATA_W-1:0]  rsp_tdata_ff;
   logic                              rsp_tlast_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff  <= asmon_pkg::BAND_LOW_RST;
         band_high_ff <= asmon_pkg::BAND_HIGH_RST;
         mean_low_ff  <= asmon_pkg::MEAN_LOW_RST;
         mean_high_ff <= asmon_pkg::MEAN_HIGH_RST;
      end else if (csr_wen) begin
         case (asmon_pkg::csr_index_type'(csr_addr))
            asmon_pkg::CSR_BAND_LOW: begin
               band_low_ff <= csr_wdata;
            end
            asmon_pkg::CSR_BAND_HIGH: begin
               band_high_ff <= csr_wdata;
            end
            asmon_pkg::CSR_MEAN_LOW: begin
               mean_low_ff <= csr_wdata;
            end
            asmon_pkg::CSR_MEAN_HIGH: begin
               mean_high_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- input side
   assign accept   = req_tvalid && req_tready;
   // a full counter drops the word but a tlast on it still reports
   assign take     = accept && !full;
   assign bin_prod = BPW'(req_tdata[SW-1:0]) * BPW'(BIN_COUNT);
   assign upd_bin  = bin_prod[BPW-1:SW];

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asmon_pkg::ST_RUN;
         bin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bin_ff   <= bin_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      bin_in      = bin_ff;
      bins_ctrl   = '0;
      rd_bin      = '0;
      rsp_load    = 1'b0;
      rsp_take    = 1'b0;
      stats_clear = 1'b0;
      req_tready  = 1'b0;
      case (state_ff)
         asmon_pkg::ST_RUN: begin
            req_tready    = 1'b1;
            bins_ctrl.upd = take;
            if (accept && req_tlast) begin
               state_in = asmon_pkg::ST_SETTLE;
            end
         end
         asmon_pkg::ST_SETTLE: begin
            // last bin write lands, pass products register
            state_in = asmon_pkg::ST_EVAL;
         end
         asmon_pkg::ST_EVAL: begin
            bins_ctrl.rd = 1'b1;
            rd_bin       = '0;
            bin_in       = '0;
            state_in     = asmon_pkg::ST_LOAD;
         end
         asmon_pkg::ST_LOAD: begin
            rsp_load = 1'b1;
            state_in = asmon_pkg::ST_HOLD;
         end
         asmon_pkg::ST_HOLD: begin
            if (rsp_tready) begin
               rsp_take = 1'b1;
               if (bin_ff == LAST_BIN) begin
                  bins_ctrl.clear = 1'b1;
                  stats_clear     = 1'b1;
                  state_in        = asmon_pkg::ST_RUN;
               end else begin
                  bins_ctrl.rd = 1'b1;
                  rd_bin       = bin_ff + BIN_W'(1);
                  bin_in       = bin_ff + BIN_W'(1);
                  state_in     = asmon_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = asmon_pkg::ST_RUN;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   asmon_stats #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_stats (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .clear       (stats_clear),
      .raw_word    (req_tdata),
      .band_low    (band_low_ff),
      .band_high   (band_high_ff),
      .mean_low    (mean_low_ff),
      .mean_high   (mean_high_ff),
      .full        (full),
      .count       (count),
      .min_value   (min_value),
      .max_value   (max_value),
      .value_sum   (value_sum),
      .square_sum  (square_sum),
      .zero_count  (zero_count),
      .upper_count (upper_count),
      .band_count  (band_count),
      .pass        (pass)
   );

   asmon_bins #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .BIN_COUNT   (BIN_COUNT)
   ) u_bins (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (bins_ctrl),
      .upd_bin  (upd_bin),
      .rd_bin   (rd_bin),
      .rd_count (rd_count)
   );

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {pass,
                          asmon_pkg::OUT_CNT_W'(band_count),
                          asmon_pkg::OUT_CNT_W'(upper_count),
                          asmon_pkg::OUT_CNT_W'(zero_count),
                          square_sum,
                          value_sum,
                          max_value,
                          min_value,
                          asmon_pkg::OUT_CNT_W'(count),
                          asmon_pkg::OUT_CNT_W'(rd_count),
                          asmon_pkg::OUT_IDX_W'(bin_ff)};
         rsp_tlast_ff <= (bin_ff == LAST_BIN);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------- checks
   // input and report never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a report is pending");

   // first report appears a fixed time after the closing word
   a_report_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> ##4 rsp_tvalid)
      else $error("report did not start after last word");

   // after the final bin the block is ready for the next run
   a_run_resume: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("input not reopened after report");

endmodule

### rtl/core/asmon_ram.sv
`timescale 1ns / 1ps
// asmon_ram: generic single-write, single-read RAM with registered read.
// Depends on asmon_pkg for defaults.
module asmon_ram #(
   parameter int WIDTH = asmon_pkg::COUNT_WIDTH_DEF,
   parameter int DEPTH = asmon_pkg::BIN_COUNT_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/asmon_bins.sv
`timescale 1ns / 1ps
// asmon_bins: histogram store, read-modify-write of bin counts in asmon_ram.
// Depends on asmon_pkg and asmon_ram.
module asmon_bins #(
   parameter int COUNT_WIDTH = asmon_pkg::COUNT_WIDTH_DEF,
   parameter int BIN_COUNT   = asmon_pkg::BIN_COUNT_DEF,
   localparam int BIN_W = $clog2(BIN_COUNT)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  asmon_pkg::bins_ctrl_type ctrl,
   input  logic [BIN_W-1:0]         upd_bin,
   input  logic [BIN_W-1:0]         rd_bin,
   output logic [COUNT_WIDTH-1:0]   rd_count
);

   logic [BIN_W-1:0]       addr;
   logic [BIN_W-1:0]       addr_ff;
   logic                   upd_ff;
   logic [BIN_COUNT-1:0]   valid_ff;
   logic                   fwd_ff;
   logic [BIN_W-1:0]       fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic [COUNT_WIDTH-1:0] ram_q;
   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] wr_data;

   assign addr = ctrl.rd ? rd_bin : upd_bin;

   asmon_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (upd_ff),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   // RAM read captures pre-write data, so the previous write is forwarded.
   // Entries never written since the last clear read as zero.
   always_comb begin
      if (fwd_ff && (fwd_addr_ff == addr_ff)) begin
         cur = fwd_data_ff;
      end else if (valid_ff[addr_ff]) begin
         cur = ram_q;
      end else begin
         cur = '0;
      end
   end

   assign wr_data  = cur + COUNT_WIDTH'(1);
   assign rd_count = cur;

   always_ff @(posedge clock) begin
      addr_ff     <= addr;
      fwd_addr_ff <= addr_ff;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         upd_ff <= ctrl.upd;
         fwd_ff <= upd_ff && !ctrl.clear;
         if (ctrl.clear) begin
            valid_ff <= '0;
         end else if (upd_ff) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

endmodule

### rtl/core/asmon_stats.sv
`timescale 1ns / 1ps
// asmon_stats: scalar run accumulators and the registered pass evaluation.
// Depends on asmon_pkg.
module asmon_stats #(
   parameter int COUNT_WIDTH = asmon_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  logic                              clear,
   input  logic [asmon_pkg::RAW_W-1:0]       raw_word,
   input  logic [asmon_pkg::SAMPLE_W-1:0]    band_low,
   input  logic [asmon_pkg::SAMPLE_W-1:0]    band_high,
   input  logic [asmon_pkg::SAMPLE_W-1:0]    mean_low,
   input  logic [asmon_pkg::SAMPLE_W-1:0]    mean_high,
   output logic                              full,
   output logic [COUNT_WIDTH-1:0]            count,
   output logic [asmon_pkg::SAMPLE_W-1:0]    min_value,
   output logic [asmon_pkg::SAMPLE_W-1:0]    max_value,
   output logic [asmon_pkg::SUM_W-1:0]       value_sum,
   output logic [asmon_pkg::SQUARE_W-1:0]    square_sum,
   output logic [COUNT_WIDTH-1:0]            zero_count,
   output logic [COUNT_WIDTH-1:0]            upper_count,
   output logic [COUNT_WIDTH-1:0]            band_count,
   output logic                              pass
);

   localparam int SW   = asmon_pkg::SAMPLE_W;
   localparam int PW   = COUNT_WIDTH + SW;
   localparam int CMPW = (PW > asmon_pkg::SUM_W) ? PW : asmon_pkg::SUM_W;
   localparam int NW   = COUNT_WIDTH + 8;

   logic [SW-1:0]                  sample;
   logic                           upper_set;
   logic                           in_band;
   logic [2*SW-1:0]                square;

   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic [SW-1:0]                  min_ff, min_in;
   logic [SW-1:0]                  max_ff, max_in;
   logic [asmon_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [asmon_pkg::SQUARE_W-1:0] sq_ff, sq_in;
   logic [COUNT_WIDTH-1:0]         zero_ff, zero_in;
   logic [COUNT_WIDTH-1:0]         upper_ff, upper_in;
   logic [COUNT_WIDTH-1:0]         band_ff, band_in;

   logic [PW-1:0]                  lo_prod_ff;
   logic [PW-1:0]                  hi_prod_ff;
   logic [NW-1:0]                  n_scaled_ff;
   logic [NW-1:0]                  b_scaled_ff;
   logic [asmon_pkg::SUM_W-1:0]    sum_s_ff;
   logic                           nz_ff;
   logic                           pass_ff;

   assign sample    = raw_word[SW-1:0];
   assign upper_set = (raw_word[asmon_pkg::RAW_W-1:SW] != '0);
   assign in_band   = (sample >= band_low) && (sample <= band_high);
   assign square    = (2*SW)'(sample) * (2*SW)'(sample);
   assign full      = (count_ff == '1);

   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      zero_in  = zero_ff;
      upper_in = upper_ff;
      band_in  = band_ff;
      if (clear) begin
         count_in = '0;
         min_in   = asmon_pkg::SAMPLE_MAX;
         max_in   = '0;
         sum_in   = '0;
         sq_in    = '0;
         zero_in  = '0;
         upper_in = '0;
         band_in  = '0;
      end else if (take) begin
         count_in = count_ff + COUNT_WIDTH'(1);
         if (sample < min_ff) begin
            min_in = sample;
         end
         if (sample > max_ff) begin
            max_in = sample;
         end
         sum_in = sum_ff + asmon_pkg::SUM_W'(sample);
         sq_in  = sq_ff + asmon_pkg::SQUARE_W'(square);
         if (sample == '0) begin
            zero_in = zero_ff + COUNT_WIDTH'(1);
         end
         if (upper_set) begin
            upper_in = upper_ff + COUNT_WIDTH'(1);
         end
         if (in_band) begin
            band_in = band_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= asmon_pkg::SAMPLE_MAX;
         max_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         zero_ff  <= '0;
         upper_ff <= '0;
         band_ff  <= '0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         zero_ff  <= zero_in;
         upper_ff <= upper_in;
         band_ff  <= band_in;
      end
   end

   // Pass check, two register stages behind the accumulators.
   // band > floor(99n/100) is evaluated as 99n < 100*band.
   always_ff @(posedge clock) begin
      lo_prod_ff  <= PW'(mean_low) * PW'(count_ff);
      hi_prod_ff  <= PW'(mean_high) * PW'(count_ff);
      n_scaled_ff <= NW'(count_ff) * NW'(asmon_pkg::PASS_NUM);
      b_scaled_ff <= NW'(band_ff) * NW'(asmon_pkg::PASS_DEN);
      sum_s_ff    <= sum_ff;
      nz_ff       <= (count_ff != '0);
      pass_ff     <= nz_ff
                     && (CMPW'(sum_s_ff) > CMPW'(lo_prod_ff))
                     && (CMPW'(sum_s_ff) < CMPW'(hi_prod_ff))
                     && (n_scaled_ff < b_scaled_ff);
   end

   assign count       = count_ff;
   assign min_value   = min_ff;
   assign max_value   = max_ff;
   assign value_sum   = sum_ff;
   assign square_sum  = sq_ff;
   assign zero_count  = zero_ff;
   assign upper_count = upper_ff;
   assign band_count  = band_ff;
   assign pass        = pass_ff;

endmodule
